/* src/cbd_pkg.sv */
package cbd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_PUSH_BACK  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    typedef struct packed {
        logic accept;
        logic pop_load;
    } t_cmd;

    typedef struct packed {
        logic pop_go;
    } t_stat;

endpackage

/* src/cbd_req_if.sv */
interface cbd_req_if import cbd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_mode                 mode;
    logic [DATA_WIDTH-1:0] push_data;

    modport source (output valid, output mode, output push_data, input ready);
    modport sink (input valid, input mode, input push_data, output ready);
endinterface

/* src/cbd_rsp_if.sv */
interface cbd_rsp_if import cbd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  ok;
    logic [DATA_WIDTH-1:0] pop_data;
    logic [CNT_W-1:0]      level;
    logic                  is_full;
    logic                  is_empty;

    modport source (
        output valid, output ok, output pop_data, output level,
        output is_full, output is_empty, input ready
    );
    modport sink (
        input valid, input ok, input pop_data, input level,
        input is_full, input is_empty, output ready
    );
endinterface

/* src/cbd_ram.sv */
module cbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/cbd_ctrl.sv */
module cbd_ctrl import cbd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic {
        S_IDLE,
        S_POP_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready     = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.accept   = i_in_valid && o_in_ready;
    assign o_cmd.pop_load = (r_state == S_POP_WAIT);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                if (r_out_valid && i_out_ready) begin
                    n_out_valid = 1'b0;
                end
                if (o_cmd.accept) begin
                    if (i_stat.pop_go) begin
                        n_state = S_POP_WAIT;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_POP_WAIT: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_wait_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_WAIT) |-> !o_in_ready)
        else $error("input taken while a pop read is pending");

    a_pop_defers_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_stat.pop_go) |=> (r_state == S_POP_WAIT && !r_out_valid))
        else $error("pop result shown before read data");

    a_wait_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_WAIT) |=> (r_out_valid && r_state == S_IDLE))
        else $error("pop result not presented after read");
`endif
endmodule

/* src/cbd_dp.sv */
module cbd_dp import cbd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  t_mode                 i_mode,
    input  logic [DATA_WIDTH-1:0] i_push_data,
    output logic                  o_ok,
    output logic [DATA_WIDTH-1:0] o_pop_data,
    output logic [CNT_W-1:0]      o_level,
    output logic                  o_is_full,
    output logic                  o_is_empty
);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);

    logic [ADDR_W-1:0]     r_front, n_front;
    logic [ADDR_W-1:0]     r_back, n_back;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_ok;
    logic [DATA_WIDTH-1:0] r_pop_data;
    logic [CNT_W-1:0]      r_level;
    logic                  r_is_full;
    logic                  r_is_empty;

    logic [ADDR_W-1:0]     front_prev, front_next, back_prev, back_next;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic                  full, empty, is_push, done, we;
    logic [DATA_WIDTH-1:0] rdata;

    assign front_prev = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign front_next = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
    assign back_prev  = (r_back == '0) ? LAST_IDX : r_back - 1'b1;
    assign back_next  = (r_back == LAST_IDX) ? '0 : r_back + 1'b1;

    assign full    = (r_count == FULL_CNT);
    assign empty   = (r_count == '0);
    assign is_push = (i_mode == MODE_PUSH_BACK) || (i_mode == MODE_PUSH_FRONT);
    assign done    = is_push ? !full : !empty;
    assign we      = i_cmd.accept && is_push && !full;

    assign waddr = (i_mode == MODE_PUSH_FRONT) ? front_prev : r_back;
    assign raddr = (i_mode == MODE_POP_BACK) ? back_prev : r_front;

    assign o_stat.pop_go = !is_push && !empty;

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_count = r_count;
        if (i_cmd.accept && done) begin
            unique case (i_mode)
                MODE_PUSH_BACK:  n_back  = back_next;
                MODE_PUSH_FRONT: n_front = front_prev;
                MODE_POP_FRONT:  n_front = front_next;
                MODE_POP_BACK:   n_back  = back_prev;
                default:         n_back  = r_back;
            endcase
            n_count = is_push ? r_count + 1'b1 : r_count - 1'b1;
        end
    end

    cbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_push_data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ok       <= done;
            r_pop_data <= '0;
            r_level    <= n_count;
            r_is_full  <= (n_count == FULL_CNT);
            r_is_empty <= (n_count == '0);
        end else if (i_cmd.pop_load) begin
            r_pop_data <= rdata;
        end
    end

    assign o_ok       = r_ok;
    assign o_pop_data = r_pop_data;
    assign o_level    = r_level;
    assign o_is_full  = r_is_full;
    assign o_is_empty = r_is_empty;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("element count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_front == r_back))
        else $error("empty deque with split pointers");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && is_push && !full) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not grow the deque");
`endif
endmodule

/* src/circular_buffer_deque.sv */
// Channel   Dir  Payload                                   Transaction
// i_req     in   mode, push_data                           valid & ready
// o_rsp     out  ok, pop_data, level, is_full, is_empty    valid & ready
//
// Push and refused operations: the result is presented in the cycle after accept.
// Successful pop: the registered read of the ring RAM, then the S_POP_WAIT state loads the result.
// A new transaction is taken while a result waits, if it leaves this cycle.
// Synchronous active-low reset clears pointers and count; the ring needs no clear.
module circular_buffer_deque import cbd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbd_req_if.sink   i_req,
    cbd_rsp_if.source o_rsp
);
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;
    logic  out_valid;

    cbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cbd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mode      (i_req.mode),
        .i_push_data (i_req.push_data),
        .o_ok        (o_rsp.ok),
        .o_pop_data  (o_rsp.pop_data),
        .o_level     (o_rsp.level),
        .o_is_full   (o_rsp.is_full),
        .o_is_empty  (o_rsp.is_empty)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
endmodule
